[design/afce_pkg.sv]
`default_nettype none

package afce_pkg;

    localparam int CountWidthDef = 14;

    localparam logic [31:0] SyncWord    = 32'hFFFF_FFFF;
    localparam logic [31:0] HeaderLimit = 32'h8000_0000;
    localparam logic [7:0]  TagReset    = 8'hEA;
    localparam logic [15:0] FrameReset  = 16'd1500;
    localparam logic signed [13:0] VoltScale = 14'sd7158;

    typedef logic signed [23:0] t_code;

    typedef enum logic [1:0] {
        PH_HUNT    = 2'd0,
        PH_HEADER  = 2'd1,
        PH_SIZE    = 2'd2,
        PH_PAYLOAD = 2'd3
    } t_phase;

    typedef enum logic {
        CFG_TAG   = 1'b0,
        CFG_FRAME = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic clear;
        logic update;
    } t_ext_ctrl;

endpackage

`default_nettype wire

[design/afce_extrema.sv]
`default_nettype none

module afce_extrema
    import afce_pkg::*;
(
    input  wire            i_clk,
    input  wire            i_rst_n,
    input  wire t_ext_ctrl i_ctrl,
    input  wire t_code     i_code,
    output t_code          o_top_max,
    output t_code          o_next_max,
    output t_code          o_top_min,
    output t_code          o_next_min
);

    t_code r_top_max, r_next_max, r_top_min, r_next_min;
    t_code n_top_max, n_next_max, n_top_min, n_next_min;
    t_code base_top_max, base_next_max, base_top_min, base_next_min;

    always_comb begin
        // restart clears before the word is applied
        base_top_max  = i_ctrl.clear ? '0 : r_top_max;
        base_next_max = i_ctrl.clear ? '0 : r_next_max;
        base_top_min  = i_ctrl.clear ? '0 : r_top_min;
        base_next_min = i_ctrl.clear ? '0 : r_next_min;

        n_top_max  = base_top_max;
        n_next_max = base_next_max;
        n_top_min  = base_top_min;
        n_next_min = base_next_min;

        if (i_ctrl.update) begin
            if (i_code > base_top_max) begin
                n_next_max = base_top_max;
                n_top_max  = i_code;
            end else if (i_code != base_top_max && i_code > base_next_max) begin
                n_next_max = i_code;
            end
            if (i_code < base_top_min) begin
                n_next_min = base_top_min;
                n_top_min  = i_code;
            end else if (i_code != base_top_min && i_code < base_next_min) begin
                n_next_min = i_code;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top_max  <= '0;
            r_next_max <= '0;
            r_top_min  <= '0;
            r_next_min <= '0;
        end else begin
            r_top_max  <= n_top_max;
            r_next_max <= n_next_max;
            r_top_min  <= n_top_min;
            r_next_min <= n_next_min;
        end
    end

    assign o_top_max  = n_top_max;
    assign o_next_max = n_next_max;
    assign o_top_min  = n_top_min;
    assign o_next_min = n_next_min;

endmodule

`default_nettype wire

[design/adc_frame_channel_extrema.sv]
// ADC frame parser with extrema tracking for one selected channel.
// Input channel: one 32-bit stream word per beat (i_in_valid / o_in_ready),
// with i_restart clearing the parser and the extrema ahead of that word.
// The parser hunts for the sync word, checks the header and the frame size
// against max_frame_bytes, then walks size/4 payload words. Payload words
// whose top byte matches channel_tag give one result beat each on the output
// channel (o_out_valid / i_out_ready): the sign-extended code, its value in
// volts (signed whole volts) and the running first and second max and min codes.
// Words that are not kept give no output beat.
// A word is taken into the input register, then handled and its result
// loaded into the output register. Throughput: one word per cycle unless a
// waiting result is stalled by the receiver; the whole parse and extrema
// update sit between those two registers.
// When the receiver stalls with a result waiting, the input register holds
// one more word and o_in_ready drops until the result is taken.
// Reset (synchronous, active low) empties both registers, returns the parser
// to hunting, zeroes the extrema and restores the register defaults.
// Config writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect at once; the user
// must make them only while the block is idle, as the block does not enforce it.
`default_nettype none

module adc_frame_channel_extrema
    import afce_pkg::*;
#(
    parameter int COUNT_WIDTH = CountWidthDef
) (
    input  wire                i_clk,
    input  wire                i_rst_n,
    input  wire                i_cfg_we,
    input  wire                i_cfg_index,
    input  wire         [15:0] i_cfg_data,
    input  wire                i_in_valid,
    output logic               o_in_ready,
    input  wire         [31:0] i_stream_word,
    input  wire                i_restart,
    output logic               o_out_valid,
    input  wire                i_out_ready,
    output logic signed [23:0] o_sample_code,
    output logic signed [20:0] o_sample_volts,
    output logic        [22:0] o_max_first,
    output logic        [22:0] o_max_second,
    output logic signed [23:0] o_min_first,
    output logic signed [23:0] o_min_second
);

    localparam logic [15:0] CountMax = 16'((32'd1 << COUNT_WIDTH) - 32'd1);

    logic [7:0]  r_tag;
    logic [15:0] r_max_bytes;

    logic        r_in_valid;
    logic [31:0] r_word;
    logic        r_restart;

    t_phase                 r_phase, n_phase;
    logic [COUNT_WIDTH-1:0] r_left, n_left;

    logic adv, fire, keep;
    t_phase                 phase_cur;
    logic [COUNT_WIDTH-1:0] left_cur, left_dec;
    logic [15:0]            quarter;
    logic [COUNT_WIDTH-1:0] frame_words;

    t_code              code;
    logic signed [37:0] volts_prod;
    t_ext_ctrl          ext_ctrl;
    t_code              ext_top_max, ext_next_max, ext_top_min, ext_next_min;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag       <= TagReset;
            r_max_bytes <= FrameReset;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_TAG:   r_tag       <= i_cfg_data[7:0];
                CFG_FRAME: r_max_bytes <= i_cfg_data;
                default:   r_tag       <= r_tag;
            endcase
        end
    end

    assign adv        = !o_out_valid || i_out_ready;
    assign fire       = r_in_valid && adv;
    assign o_in_ready = !r_in_valid || adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_word    <= i_stream_word;
            r_restart <= i_restart;
        end
    end

    assign quarter     = {2'b00, r_word[15:2]};
    assign frame_words = (quarter > CountMax) ? '1 : quarter[COUNT_WIDTH-1:0];

    always_comb begin
        phase_cur = r_restart ? PH_HUNT : r_phase;
        left_cur  = r_restart ? '0 : r_left;
        left_dec  = (left_cur != '0) ? left_cur - 1'b1 : left_cur;
        n_phase   = r_phase;
        n_left    = r_left;
        keep      = 1'b0;
        if (fire) begin
            n_phase = phase_cur;
            n_left  = left_cur;
            case (phase_cur)
                PH_HUNT: begin
                    if (r_word == SyncWord) n_phase = PH_HEADER;
                end
                PH_HEADER: begin
                    n_phase = (r_word < HeaderLimit) ? PH_SIZE : PH_HUNT;
                end
                PH_SIZE: begin
                    if (r_word > {16'h0000, r_max_bytes}) begin
                        n_phase = PH_HUNT;
                    end else begin
                        n_left  = frame_words;
                        n_phase = (frame_words == '0) ? PH_HUNT : PH_PAYLOAD;
                    end
                end
                PH_PAYLOAD: begin
                    n_left = left_dec;
                    if (left_dec == '0) n_phase = PH_HUNT;
                    keep = (r_word[31:24] == r_tag);
                end
                default: n_phase = PH_HUNT;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HUNT;
            r_left  <= '0;
        end else begin
            r_phase <= n_phase;
            r_left  <= n_left;
        end
    end

    assign code       = $signed(r_word[23:0]);
    // arithmetic shift of the product floors toward minus infinity
    assign volts_prod = code * VoltScale;

    assign ext_ctrl.clear  = fire && r_restart;
    assign ext_ctrl.update = keep;

    afce_extrema u_extrema (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ctrl     (ext_ctrl),
        .i_code     (code),
        .o_top_max  (ext_top_max),
        .o_next_max (ext_next_max),
        .o_top_min  (ext_top_min),
        .o_next_min (ext_next_min)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_out_valid <= 1'b0;
        end else if (adv) begin
            o_out_valid <= keep;
        end
    end

    always_ff @(posedge i_clk) begin
        if (keep) begin
            o_sample_code  <= code;
            o_sample_volts <= volts_prod[36:16];
            o_max_first    <= ext_top_max[22:0];
            o_max_second   <= ext_next_max[22:0];
            o_min_first    <= ext_top_min;
            o_min_second   <= ext_next_min;
        end
    end

endmodule

`default_nettype wire

[design/afce_checker.sv]
`default_nettype none

module afce_checker (
    input wire               i_clk,
    input wire               i_rst_n,
    input wire               o_in_ready,
    input wire               o_out_valid,
    input wire               i_out_ready,
    input wire signed [23:0] o_sample_code,
    input wire signed [20:0] o_sample_volts,
    input wire        [22:0] o_max_first,
    input wire        [22:0] o_max_second,
    input wire signed [23:0] o_min_first,
    input wire signed [23:0] o_min_second
);

    // a stalled result beat holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
            (o_out_valid && $stable(o_sample_code) && $stable(o_sample_volts) &&
             $stable(o_max_first) && $stable(o_max_second) &&
             $stable(o_min_first) && $stable(o_min_second)))
        else $error("result beat changed while stalled");

    a_max_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_max_first >= o_max_second))
        else $error("second max above first max");

    a_min_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_min_first <= o_min_second))
        else $error("second min below first min");

    a_code_bounds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ($signed({1'b0, o_max_first}) >= o_sample_code &&
                         o_min_first <= o_sample_code))
        else $error("sample code outside tracked extrema");

    // with no result pending the input side never stalls
    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> o_in_ready)
        else $error("input stalled with empty output");

endmodule

bind adc_frame_channel_extrema afce_checker u_afce_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_in_ready     (o_in_ready),
    .o_out_valid    (o_out_valid),
    .i_out_ready    (i_out_ready),
    .o_sample_code  (o_sample_code),
    .o_sample_volts (o_sample_volts),
    .o_max_first    (o_max_first),
    .o_max_second   (o_max_second),
    .o_min_first    (o_min_first),
    .o_min_second   (o_min_second)
);

`default_nettype wire

[bench/tb_top.sv]
`timescale 1ns / 1ps

module tb_top;
    import afce_pkg::*;

    localparam int COUNT_WIDTH = CountWidthDef;
    localparam logic [31:0] COUNT_MAX = (32'd1 << COUNT_WIDTH) - 32'd1;
    localparam logic signed [47:0] VOLTS_PER_CODE_Q16 = 48'sd7158;
    localparam int IDLE_PCT = 31;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int DRAIN_CYCLES = 6;
    localparam int DRAIN_GUARD = 20000;
    localparam int REPORT_LIMIT = 10;

    typedef struct {
        logic [31:0] word;
        logic        restart;
    } t_stream_beat;

    typedef struct {
        t_code              code;
        logic signed [20:0] volts;
        logic        [22:0] max1;
        logic        [22:0] max2;
        t_code              min1;
        t_code              min2;
    } t_sample_beat;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic i_cfg_index = 1'b0;
    logic [15:0] i_cfg_data = 16'd0;
    logic i_in_valid = 1'b0;
    logic o_in_ready;
    logic [31:0] i_stream_word = 32'd0;
    logic i_restart = 1'b0;
    logic o_out_valid;
    logic i_out_ready = 1'b0;
    logic signed [23:0] o_sample_code;
    logic signed [20:0] o_sample_volts;
    logic [22:0] o_max_first;
    logic [22:0] o_max_second;
    logic signed [23:0] o_min_first;
    logic signed [23:0] o_min_second;

    adc_frame_channel_extrema #(
        .COUNT_WIDTH(COUNT_WIDTH)
    ) dut (.*);

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    t_stream_beat pending_words[$];
    t_sample_beat sample_expect[$];
    t_stream_beat next_beat;
    t_sample_beat want_beat;
    int words_queued = 0;
    int mismatches = 0;
    logic calm = 1'b0;
    logic [23:0] last_low = 24'd0;

    // receiver hold-off, requested by the stimulus and timed here
    int hold_requests = 0;
    int hold_served = 0;
    int hold_count = 0;
    logic rx_holding = 1'b0;

    // tracked copy of the block's configuration and parser
    logic [7:0] tag_cfg = TagReset;
    logic [15:0] frame_limit = FrameReset;
    t_phase parse_at = PH_HUNT;
    logic [COUNT_WIDTH-1:0] words_left = '0;
    t_code top_max = '0;
    t_code next_max = '0;
    t_code top_min = '0;
    t_code next_min = '0;

    function automatic void clear_tracker();
        parse_at = PH_HUNT;
        words_left = '0;
        top_max = '0;
        next_max = '0;
        top_min = '0;
        next_min = '0;
    endfunction

    function automatic void track_word(logic [31:0] w, logic rs);
        logic [31:0] quarter;
        t_code code;
        logic signed [47:0] prod;
        t_sample_beat b;
        if (rs) clear_tracker();
        case (parse_at)
            PH_HUNT: begin
                if (w == SyncWord) parse_at = PH_HEADER;
            end
            PH_HEADER: begin
                if (w < HeaderLimit) parse_at = PH_SIZE;
                else parse_at = PH_HUNT;
            end
            PH_SIZE: begin
                if (w > {16'd0, frame_limit}) begin
                    parse_at = PH_HUNT;
                end else begin
                    quarter = w >> 2;
                    if (quarter > COUNT_MAX) quarter = COUNT_MAX;
                    words_left = quarter[COUNT_WIDTH-1:0];
                    if (quarter == 32'd0) parse_at = PH_HUNT;
                    else parse_at = PH_PAYLOAD;
                end
            end
            default: begin
                if (words_left != '0) words_left = words_left - 1'b1;
                if (words_left == '0) parse_at = PH_HUNT;
                if (w[31:24] == tag_cfg) begin
                    code = t_code'(w[23:0]);
                    if (code > top_max) begin
                        next_max = top_max;
                        top_max = code;
                    end else if (code != top_max && code > next_max) begin
                        next_max = code;
                    end
                    if (code < top_min) begin
                        next_min = top_min;
                        top_min = code;
                    end else if (code != top_min && code < next_min) begin
                        next_min = code;
                    end
                    // floor division by 2^16 is the bit slice of the product
                    prod = code * VOLTS_PER_CODE_Q16;
                    b.code = code;
                    b.volts = prod[36:16];
                    b.max1 = top_max[22:0];
                    b.max2 = next_max[22:0];
                    b.min1 = top_min;
                    b.min2 = next_min;
                    sample_expect.push_back(b);
                end
            end
        endcase
    endfunction

    // input side: one beat offered at a time from the pending queue
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) track_word(i_stream_word, i_restart);
            if (!i_in_valid || o_in_ready) begin
                if (pending_words.size() != 0 && (calm || $urandom_range(0, 99) >= IDLE_PCT)) begin
                    next_beat = pending_words.pop_front();
                    i_stream_word <= next_beat.word;
                    i_restart <= next_beat.restart;
                    i_in_valid <= 1'b1;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // output side
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (sample_expect.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("unexpected result beat: code %0d volts %0d",
                                 o_sample_code, o_sample_volts);
                end else begin
                    want_beat = sample_expect.pop_front();
                    if (o_sample_code !== want_beat.code || o_sample_volts !== want_beat.volts
                        || o_max_first !== want_beat.max1 || o_max_second !== want_beat.max2
                        || o_min_first !== want_beat.min1 || o_min_second !== want_beat.min2)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display({"result beat mismatch (exp/got): code %0d/%0d ",
                                      "volts %0d/%0d max %0d,%0d/%0d,%0d min %0d,%0d/%0d,%0d"},
                                     want_beat.code, o_sample_code,
                                     want_beat.volts, o_sample_volts,
                                     want_beat.max1, want_beat.max2, o_max_first, o_max_second,
                                     want_beat.min1, want_beat.min2, o_min_first, o_min_second);
                    end
                end
            end
            i_out_ready <= !rx_holding && (calm || $urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    always @(posedge i_clk) begin
        if (rx_holding) begin
            if (hold_count == RX_HOLD_CYCLES - 1) rx_holding <= 1'b0;
            hold_count <= hold_count + 1;
        end else if (hold_served != hold_requests) begin
            rx_holding <= 1'b1;
            hold_count <= 0;
            hold_served <= hold_requests;
        end
    end

    function automatic bit per_mille(int n);
        return $urandom_range(0, 999) < n;
    endfunction

    function automatic void queue_word(logic [31:0] w, logic rs);
        t_stream_beat b;
        b.word = w;
        b.restart = rs;
        pending_words.push_back(b);
        words_queued++;
    endfunction

    function automatic logic [31:0] pick_header();
        int r;
        r = $urandom_range(0, 99);
        if (r < 5) return 32'd0;
        if (r < 10) return HeaderLimit - 32'd1;
        return $urandom >> 1;
    endfunction

    function automatic logic [31:0] pick_payload();
        logic [23:0] low;
        int r;
        r = $urandom_range(0, 99);
        if (r < 10) begin
            case ($urandom_range(0, 4))
                0: low = 24'h000000;
                1: low = 24'h7FFFFF;
                2: low = 24'h800000;
                3: low = 24'hFFFFFF;
                default: low = 24'h000001;
            endcase
        end else if (r < 25) begin
            low = last_low;
        end else if (r < 60) begin
            low = 24'($urandom_range(0, 2000)) - 24'd1000;
        end else begin
            low = 24'($urandom);
        end
        last_low = low;
        r = $urandom_range(0, 99);
        if (r < 78) return {tag_cfg, low};
        if (r < 84) return SyncWord;
        return $urandom;
    endfunction

    function automatic void queue_frame();
        int nbytes;
        int i;
        queue_word(SyncWord, per_mille(15));
        queue_word(pick_header(), per_mille(10));
        nbytes = $urandom_range(0, 60);
        if (frame_limit <= 16'd256 && $urandom_range(0, 9) == 0) nbytes = int'(frame_limit);
        if (nbytes > int'(frame_limit)) nbytes = int'(frame_limit);
        queue_word(32'(nbytes), per_mille(10));
        for (i = 0; i < nbytes / 4; i++) queue_word(pick_payload(), per_mille(15));
    endfunction

    function automatic void queue_broken();
        queue_word(SyncWord, 1'b0);
        case ($urandom_range(0, 3))
            0: queue_word(HeaderLimit | $urandom, 1'b0);
            1: begin
                queue_word(pick_header(), 1'b0);
                if ($urandom_range(0, 1) == 0)
                    queue_word({16'd0, frame_limit} + 32'd1 + $urandom_range(0, 300), 1'b0);
                else
                    queue_word($urandom | 32'h0001_0000, 1'b0);
            end
            2: begin
                // frame cut short: the next sync lands inside the payload unless the frame limit is under 12 bytes
                queue_word(pick_header(), 1'b0);
                queue_word((frame_limit < 16'd40) ? {16'd0, frame_limit} : 32'd40, 1'b0);
                queue_word(pick_payload(), 1'b0);
                queue_word(pick_payload(), 1'b0);
                queue_word(SyncWord, 1'b0);
            end
            default: queue_word(SyncWord, 1'b0);
        endcase
    endfunction

    function automatic void queue_random(int n_words);
        int target;
        int r;
        int i;
        target = words_queued + n_words;
        while (words_queued < target) begin
            r = $urandom_range(0, 99);
            if (r < 72) begin
                queue_frame();
            end else if (r < 86) begin
                queue_broken();
            end else begin
                for (i = $urandom_range(1, 4); i > 0; i--)
                    queue_word(($urandom_range(0, 7) == 0) ? SyncWord : $urandom, per_mille(10));
            end
        end
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [15:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_TAG) tag_cfg = data[7:0];
        else frame_limit = data;
    endtask

    task automatic drain_block();
        int guard;
        guard = 0;
        while ((pending_words.size() != 0 || i_in_valid || sample_expect.size() != 0)
               && guard < DRAIN_GUARD) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic set_and_run(logic [7:0] tag, logic [15:0] limit, int n_words);
        write_reg(CFG_TAG, {8'($urandom), tag});
        write_reg(CFG_FRAME, limit);
        @(negedge i_clk);
        queue_random(n_words);
    endtask

    initial begin
        clear_tracker();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed beats under the reset configuration
        queue_word(SyncWord, 1'b1);
        queue_word(32'd0, 1'b0);
        queue_word(32'd16, 1'b0);
        queue_word(32'hEA7F_FFFF, 1'b0);
        queue_word(32'hEA80_0000, 1'b0);
        queue_word(32'hEA00_0000, 1'b0);
        queue_word(32'hEAFF_FFFF, 1'b0);
        queue_word(SyncWord, 1'b0);
        queue_word(HeaderLimit, 1'b0);              // bad header
        queue_word(SyncWord, 1'b0);
        queue_word(HeaderLimit - 32'd1, 1'b0);
        queue_word(32'd1501, 1'b0);                 // oversized frame
        queue_word(SyncWord, 1'b0);
        queue_word(32'd1, 1'b0);
        queue_word(32'd3, 1'b0);                    // empty frame
        queue_word(SyncWord, 1'b0);
        queue_word(32'h1234_5678, 1'b0);
        queue_word(32'd12, 1'b0);
        queue_word(SyncWord, 1'b0);                 // sync inside payload
        queue_word(32'hEA7F_FFFF, 1'b0);            // equal to the top max
        queue_word(32'h12EA_0000, 1'b0);
        queue_word(SyncWord, 1'b0);
        queue_word(32'd0, 1'b0);
        queue_word(32'd1500, 1'b0);                 // size right at the limit
        queue_word(32'hEA00_0005, 1'b0);
        queue_word(SyncWord, 1'b1);                 // restart mid frame
        queue_word(32'd0, 1'b0);
        queue_word(32'd8, 1'b0);
        queue_word(32'hEA00_0003, 1'b0);
        queue_word(32'hEAFF_FFFE, 1'b0);
        drain_block();

        set_and_run(8'h3C, 16'hFFFF, 150);
        // largest frame size, cut off by a restart
        queue_word(SyncWord, 1'b0);
        queue_word(pick_header(), 1'b0);
        queue_word(32'd65535, 1'b0);
        queue_word(pick_payload(), 1'b0);
        queue_word(pick_payload(), 1'b0);
        queue_word($urandom, 1'b1);
        drain_block();

        set_and_run(8'hFF, 16'd0, 60);
        drain_block();

        set_and_run(8'h00, 16'd37, 150);
        drain_block();

        // receiver holds off while the sender keeps offering beats
        set_and_run(8'($urandom), FrameReset, 200);
        hold_requests <= hold_requests + 1;
        drain_block();

        calm <= 1'b1;
        set_and_run(TagReset, 16'($urandom_range(16, 255)), 150);
        drain_block();
        calm <= 1'b0;

        set_and_run(8'($urandom), 16'hFFFF, 150);
        drain_block();

        if (mismatches == 0 && sample_expect.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

[filelist.f]
design/afce_pkg.sv
design/afce_extrema.sv
design/adc_frame_channel_extrema.sv
design/afce_checker.sv
bench/tb_top.sv
